// ===== rtl/mfc_pkg.sv =====
// Shared types, constants and the CRC byte update for the message framer.
`timescale 1ns / 1ps

package mfc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  LEN_BIAS = 8'h05;

    localparam logic       OP_START = 1'b0;
    localparam logic       OP_DATA  = 1'b1;

    localparam logic [1:0] CFG_START_MARKER = 2'd0;
    localparam logic [1:0] CFG_END_MARKER   = 2'd1;
    localparam logic [1:0] CFG_OWN_ADDRESS  = 2'd2;

    // Steps within a header command
    localparam logic [2:0] STEP_START  = 3'd0;
    localparam logic [2:0] STEP_OWN    = 3'd1;
    localparam logic [2:0] STEP_DEST   = 3'd2;
    localparam logic [2:0] STEP_FNUM   = 3'd3;
    localparam logic [2:0] STEP_LEN    = 3'd4;
    localparam logic [2:0] STEP_CODE   = 3'd5;
    localparam logic [2:0] STEP_HCRC   = 3'd6;
    localparam logic [2:0] STEP_HEND   = 3'd7;
    // Steps within a data command
    localparam logic [2:0] STEP_DATA   = 3'd0;
    localparam logic [2:0] STEP_DCRC   = 3'd1;
    localparam logic [2:0] STEP_DEND   = 3'd2;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] own_address;
    } t_cfg;

    // One classified item: error, header (with or without close) or data
    typedef struct packed {
        logic       err;
        logic       hdr;
        logic       close;
        logic [7:0] dest_or_data;
        logic [7:0] frame_num;
        logic [7:0] len;
        logic [7:0] code;
    } t_cmd;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/mfc_queue.sv =====
// Small flop-based command queue between front and back.
`timescale 1ns / 1ps

module mfc_queue
    import mfc_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_FULL);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ===== rtl/mfc_front.sv =====
// Front end: accepts input beats, tracks frame state and classifies each item.
`timescale 1ns / 1ps

module mfc_front
    import mfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_opcode,
    input  logic [7:0] i_dest_address,
    input  logic [7:0] i_function_code,
    input  logic [7:0] i_payload_count,
    input  logic [7:0] i_payload_byte,
    input  logic       i_queue_full,
    output logic       o_stall,
    output logic       o_push,
    output t_cmd       o_push_cmd
);

    logic       r_frame_open, n_frame_open;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_frame_num,  n_frame_num;
    logic       accept;
    logic [7:0] fnum_inc;

    assign o_stall  = i_queue_full;
    assign accept   = i_valid && !i_queue_full;
    assign o_push   = accept;
    assign fnum_inc = r_frame_num + 8'd1;

    always_comb begin
        n_frame_open = r_frame_open;
        n_bytes_left = r_bytes_left;
        n_frame_num  = r_frame_num;
        o_push_cmd.err          = 1'b0;
        o_push_cmd.hdr          = 1'b0;
        o_push_cmd.close        = 1'b0;
        o_push_cmd.dest_or_data = i_payload_byte;
        o_push_cmd.frame_num    = fnum_inc;
        o_push_cmd.len          = i_function_code + i_payload_count + LEN_BIAS;
        o_push_cmd.code         = i_function_code;
        if (i_opcode == OP_START) begin
            o_push_cmd.dest_or_data = i_dest_address;
            if (r_frame_open) begin
                o_push_cmd.err = 1'b1;
            end else begin
                o_push_cmd.hdr = 1'b1;
                o_push_cmd.close = (i_payload_count == 8'd0);
                n_frame_num  = fnum_inc;
                n_frame_open = (i_payload_count != 8'd0);
                n_bytes_left = i_payload_count;
            end
        end else begin
            if (!r_frame_open) begin
                o_push_cmd.err = 1'b1;
            end else begin
                o_push_cmd.close = (r_bytes_left == 8'd1);
                n_bytes_left = r_bytes_left - 8'd1;
                n_frame_open = (r_bytes_left != 8'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_bytes_left <= '0;
            r_frame_num  <= '0;
        end else if (accept) begin
            r_frame_open <= n_frame_open;
            r_bytes_left <= n_bytes_left;
            r_frame_num  <= n_frame_num;
        end
    end

endmodule

// ===== rtl/mfc_back.sv =====
// Back end: expands queued commands into frame bytes, runs the CRC, holds the output beat.
`timescale 1ns / 1ps

module mfc_back
    import mfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_cmd       i_head,
    input  logic       i_empty,
    output logic       o_pop,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [7:0] o_frame_byte,
    output logic       o_frame_end,
    output logic       o_item_error,
    output logic       o_last_of_run
);

    logic [2:0]  r_step;
    logic [15:0] r_crc, n_crc;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_end, r_err, r_last;

    logic        out_free, fire, is_last;
    logic [2:0]  last_step;
    logic [7:0]  cur_byte;
    logic        cur_feed, cur_end;
    logic [15:0] crc_base;

    assign out_free = !r_valid || !i_stall;
    assign fire     = !i_empty && out_free;
    assign is_last  = (r_step == last_step);
    assign o_pop    = fire && is_last;

    always_comb begin
        if (i_head.err) begin
            last_step = STEP_START;
        end else if (i_head.hdr) begin
            last_step = i_head.close ? STEP_HEND : STEP_CODE;
        end else begin
            last_step = i_head.close ? STEP_DEND : STEP_DATA;
        end
    end

    always_comb begin
        cur_byte = 8'h00;
        cur_feed = 1'b0;
        cur_end  = 1'b0;
        if (i_head.err) begin
            cur_byte = 8'h00;
        end else if (i_head.hdr) begin
            cur_feed = 1'b1;
            case (r_step)
                STEP_START: cur_byte = i_cfg.start_marker;
                STEP_OWN:   cur_byte = i_cfg.own_address;
                STEP_DEST:  cur_byte = i_head.dest_or_data;
                STEP_FNUM:  cur_byte = i_head.frame_num;
                STEP_LEN:   cur_byte = i_head.len;
                STEP_CODE:  cur_byte = i_head.code;
                STEP_HCRC: begin
                    cur_byte = r_crc[7:0];
                    cur_feed = 1'b0;
                end
                default: begin
                    cur_byte = i_cfg.end_marker;
                    cur_feed = 1'b0;
                    cur_end  = 1'b1;
                end
            endcase
        end else begin
            case (r_step)
                STEP_DATA: begin
                    cur_byte = i_head.dest_or_data;
                    cur_feed = 1'b1;
                end
                STEP_DCRC: cur_byte = r_crc[7:0];
                default: begin
                    cur_byte = i_cfg.end_marker;
                    cur_end  = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        crc_base = (i_head.hdr && r_step == STEP_START) ? CRC_INIT : r_crc;
        n_crc    = r_crc;
        if (cur_feed) begin
            n_crc = crc_byte(crc_base, cur_byte);
        end else if (cur_end) begin
            n_crc = CRC_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
            r_crc   <= CRC_INIT;
        end else if (fire) begin
            r_valid <= 1'b1;
            r_step  <= is_last ? 3'd0 : r_step + 3'd1;
            r_crc   <= n_crc;
        end else if (out_free) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_byte <= cur_byte;
            r_end  <= cur_end;
            r_err  <= i_head.err;
            r_last <= is_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_frame_byte  = r_byte;
    assign o_frame_end   = r_end;
    assign o_item_error  = r_err;
    assign o_last_of_run = r_last;

endmodule

// ===== rtl/message_framer_crc16.sv =====
// Message framer with CRC-16/Modbus: top level with configuration registers.
// An item's first result beat passes the command queue, then the output register.
// Back end: one result beat per cycle unless the queue is empty or output stalled;
// beats per item: data 1, closing data 3, start 6 (8 for zero payload count), error 1.
// Input stalls only when the command queue (QUEUE_DEPTH entries) is full.
// Reset (synchronous, active low) empties the queue and output, clears frame state,
// sets the CRC to all ones and the marker and address registers to zero.
`timescale 1ns / 1ps

module message_framer_crc16
    import mfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_opcode,
    input  logic [7:0] i_dest_address,
    input  logic [7:0] i_function_code,
    input  logic [7:0] i_payload_count,
    input  logic [7:0] i_payload_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_frame_byte,
    output logic       o_frame_end,
    output logic       o_item_error,
    output logic       o_last_of_run
);

    t_cfg r_cfg;
    t_cmd push_cmd, head;
    logic push, pop, q_empty, q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_START_MARKER: r_cfg.start_marker <= i_cfg_data;
                CFG_END_MARKER:   r_cfg.end_marker   <= i_cfg_data;
                CFG_OWN_ADDRESS:  r_cfg.own_address  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mfc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_opcode        (i_opcode),
        .i_dest_address  (i_dest_address),
        .i_function_code (i_function_code),
        .i_payload_count (i_payload_count),
        .i_payload_byte  (i_payload_byte),
        .i_queue_full    (q_full),
        .o_stall         (o_stall),
        .o_push          (push),
        .o_push_cmd      (push_cmd)
    );

    mfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_head     (head),
        .o_empty    (q_empty),
        .o_full     (q_full)
    );

    mfc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_head        (head),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_frame_byte  (o_frame_byte),
        .o_frame_end   (o_frame_end),
        .o_item_error  (o_item_error),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== rtl/mfc_checker.sv =====
// Port-level checks for the message framer, bound to the top level.
`timescale 1ns / 1ps

module mfc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_frame_byte,
    input logic       o_frame_end,
    input logic       o_item_error,
    input logic       o_last_of_run
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frame_byte) && $stable(o_frame_end)
            && $stable(o_item_error) && $stable(o_last_of_run))
        else $error("output beat changed while stalled");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item_error |-> o_last_of_run && !o_frame_end && o_frame_byte == 8'h00)
        else $error("malformed error beat");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_last_of_run && !o_item_error)
        else $error("frame end beat not last of its item");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind message_framer_crc16 mfc_checker u_mfc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_frame_byte  (o_frame_byte),
    .o_frame_end   (o_frame_end),
    .o_item_error  (o_item_error),
    .o_last_of_run (o_last_of_run)
);
